/* rtl/bsim_pkg.sv */
// Shared types and codes for the bank switch / scanline interrupt mapper.
// Used by bsim_core and bank_switch_scanline_irq_mapper_top; no dependencies.
`timescale 1ns / 1ps

package bsim_pkg;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_A12   = 2'd1,
    MODE_PRG   = 2'd2,
    MODE_CHR   = 2'd3
  } mode_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_PRG_MASK   = 2'd0;
  localparam logic [1:0] CFG_CHR_ROM    = 2'd1;
  localparam logic [1:0] CFG_FOUR_SCR   = 2'd2;
  localparam logic [1:0] CFG_ALT_IRQ    = 2'd3;

  // CPU register decode: {address[15:13], address[0]}
  localparam logic [3:0] REG_BANK_SEL   = 4'b1000;
  localparam logic [3:0] REG_BANK_DATA  = 4'b1001;
  localparam logic [3:0] REG_MIRROR     = 4'b1010;
  localparam logic [3:0] REG_RAM_PROT   = 4'b1011;
  localparam logic [3:0] REG_IRQ_LATCH  = 4'b1100;
  localparam logic [3:0] REG_IRQ_RELOAD = 4'b1101;
  localparam logic [3:0] REG_IRQ_OFF    = 4'b1110;
  localparam logic [3:0] REG_IRQ_ON     = 4'b1111;

  localparam int unsigned ChrBanks = 6;
  localparam int unsigned PrgBanks = 2;

  typedef struct packed {
    logic [7:0] prg_bank_mask;
    logic       chr_rom_present;
    logic       four_screen;
    logic       alt_irq_revision;
  } cfg_t;

  typedef struct packed {
    logic       prg_ram_writable;
    logic       prg_ram_enabled;
    logic       mirroring_horizontal;
    logic       irq_line;
    logic       bank_is_rom;
    logic [7:0] bank;
  } result_t;

endpackage

/* rtl/bsim_core.sv */
// Mapper state and single-pass item logic: register decode, A12 counter, lookups.
// Depends on bsim_pkg.
`timescale 1ns / 1ps

module bsim_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bsim_pkg::cfg_t   cfg_i,
  input  logic             item_en_i,
  input  bsim_pkg::mode_e  mode_i,
  input  logic [15:0]      address_i,
  input  logic [7:0]       data_i,
  output bsim_pkg::result_t res_o
);

  logic [2:0] bank_sel_q, bank_sel_d;
  logic       chr_inv_q, chr_inv_d;
  logic       prg_swap_q, prg_swap_d;
  logic [7:0] chr_bank_q [bsim_pkg::ChrBanks];
  logic [7:0] chr_bank_d [bsim_pkg::ChrBanks];
  logic [7:0] prg_bank_q [bsim_pkg::PrgBanks];
  logic [7:0] prg_bank_d [bsim_pkg::PrgBanks];
  logic [7:0] count_q, count_d;
  logic [7:0] latch_q, latch_d;
  logic       armed_q, armed_d;
  logic       reload_q, reload_d;
  logic       level_q, level_d;
  logic       mirror_q, mirror_d;
  logic       ram_en_q, ram_en_d;
  logic       ram_wr_q, ram_wr_d;

  logic [7:0] second_last;
  logic [2:0] slot;
  logic [3:0] reg_code;

  assign second_last = cfg_i.prg_bank_mask - 8'd1;
  assign slot        = address_i[12:10] ^ {chr_inv_q, 2'b00};
  assign reg_code    = {address_i[15:13], address_i[0]};

  always_comb begin
    bank_sel_d = bank_sel_q;
    chr_inv_d  = chr_inv_q;
    prg_swap_d = prg_swap_q;
    chr_bank_d = chr_bank_q;
    prg_bank_d = prg_bank_q;
    count_d    = count_q;
    latch_d    = latch_q;
    armed_d    = armed_q;
    reload_d   = reload_q;
    level_d    = level_q;
    mirror_d   = mirror_q;
    ram_en_d   = ram_en_q;
    ram_wr_d   = ram_wr_q;
    res_o      = '0;

    unique case (mode_i)
      bsim_pkg::MODE_WRITE: begin
        unique case (reg_code)
          bsim_pkg::REG_BANK_SEL: begin
            bank_sel_d = data_i[2:0];
            chr_inv_d  = data_i[7];
            prg_swap_d = data_i[6];
          end
          bsim_pkg::REG_BANK_DATA: begin
            if (bank_sel_q < 3'd6) begin
              chr_bank_d[bank_sel_q] = data_i;
            end else begin
              prg_bank_d[bank_sel_q[0]] = data_i & cfg_i.prg_bank_mask;
            end
          end
          bsim_pkg::REG_MIRROR: begin
            if (!cfg_i.four_screen) begin
              mirror_d = data_i[0];
            end
          end
          bsim_pkg::REG_RAM_PROT: begin
            ram_en_d = data_i[7];
            ram_wr_d = !data_i[6];
          end
          bsim_pkg::REG_IRQ_LATCH: begin
            latch_d = data_i;
          end
          bsim_pkg::REG_IRQ_RELOAD: begin
            if (cfg_i.alt_irq_revision) begin
              reload_d = 1'b1;
            end
            count_d = 8'd0;
          end
          bsim_pkg::REG_IRQ_OFF: begin
            armed_d = 1'b0;
            level_d = 1'b0;
          end
          bsim_pkg::REG_IRQ_ON: begin
            armed_d = 1'b1;
          end
          default: begin
          end
        endcase
      end
      bsim_pkg::MODE_A12: begin
        if (count_q == 8'd0 || reload_q) begin
          count_d = latch_q;
        end else begin
          count_d = count_q - 8'd1;
        end
        if ((!cfg_i.alt_irq_revision || count_q != 8'd0 || reload_q) &&
            count_d == 8'd0 && armed_q) begin
          level_d = 1'b1;
        end
        reload_d = 1'b0;
      end
      bsim_pkg::MODE_PRG: begin
        res_o.bank_is_rom = 1'b1;
        case (address_i[14:13])
          2'd0:    res_o.bank = prg_swap_q ? second_last : prg_bank_q[0];
          2'd1:    res_o.bank = prg_bank_q[1];
          2'd2:    res_o.bank = prg_swap_q ? prg_bank_q[0] : second_last;
          default: res_o.bank = cfg_i.prg_bank_mask;
        endcase
      end
      bsim_pkg::MODE_CHR: begin
        res_o.bank_is_rom = cfg_i.chr_rom_present;
        if (!slot[2]) begin
          res_o.bank = {chr_bank_q[{2'b00, slot[1]}][7:1], slot[0]};
        end else begin
          res_o.bank = chr_bank_q[slot - 3'd2];
        end
      end
      default: begin
      end
    endcase

    res_o.irq_line             = level_d;
    res_o.mirroring_horizontal = mirror_d;
    res_o.prg_ram_enabled      = ram_en_d;
    res_o.prg_ram_writable     = ram_wr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_sel_q <= '0;
      chr_inv_q  <= 1'b0;
      prg_swap_q <= 1'b0;
      for (int i = 0; i < bsim_pkg::ChrBanks; i++) begin
        chr_bank_q[i] <= '0;
      end
      prg_bank_q[0] <= 8'd0;
      prg_bank_q[1] <= 8'd1;
      count_q    <= '0;
      latch_q    <= 8'hFF;
      armed_q    <= 1'b0;
      reload_q   <= 1'b0;
      level_q    <= 1'b0;
      mirror_q   <= 1'b0;
      ram_en_q   <= 1'b0;
      ram_wr_q   <= 1'b1;
    end else if (item_en_i) begin
      bank_sel_q <= bank_sel_d;
      chr_inv_q  <= chr_inv_d;
      prg_swap_q <= prg_swap_d;
      chr_bank_q <= chr_bank_d;
      prg_bank_q <= prg_bank_d;
      count_q    <= count_d;
      latch_q    <= latch_d;
      armed_q    <= armed_d;
      reload_q   <= reload_d;
      level_q    <= level_d;
      mirror_q   <= mirror_d;
      ram_en_q   <= ram_en_d;
      ram_wr_q   <= ram_wr_d;
    end
  end

endmodule

/* rtl/bank_switch_scanline_irq_mapper_top.sv */
// Top level of the bank switch / scanline interrupt mapper: stream ports,
// configuration registers and output buffering. Depends on bsim_pkg, bsim_core.
`timescale 1ns / 1ps
//
// Usage
//   s_axis carries one item per handshake: tuser holds the mode (CPU write,
//   A12 rising edge, program lookup, graphics lookup), tdata the address and
//   write data. m_axis returns exactly one result item per input item, in
//   order: bank number in tdata[7:0], interrupt level, mirroring and work RAM
//   flags above it, and the ROM/RAM flag of the lookup in tuser.
//   cfg_* writes the four configuration registers by index; it is always
//   ready and must only be used while no result is outstanding.
//   Results are registered in the output buffer before m_axis_tvalid shows
//   them; throughput is one item per cycle while s_axis_tready is high, set
//   by the single register stage around bsim_core's decode and counter logic.
//   A two-entry output buffer (result register plus skid register) lets an
//   item be taken while the previous result waits; when the receiver stalls
//   for more than one item, s_axis_tready drops until the skid entry drains.
//   Reset clears all mapper state to its power-up values, restores the
//   configuration defaults and empties the output buffer.

module bank_switch_scanline_irq_mapper_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // address[15:0], data[23:16]
  input  logic [1:0]  s_axis_tuser,   // mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // bank[7:0], irq_line[8], mirroring_horizontal[9],
                                      // prg_ram_enabled[10], prg_ram_writable[11], zero[15:12]
  output logic [0:0]  m_axis_tuser,   // bank_is_rom[0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  bsim_pkg::cfg_t    cfg_q;
  bsim_pkg::result_t res;
  bsim_pkg::result_t out_q, skid_q;
  logic              out_valid_q, skid_valid_q;
  logic              in_accept, out_pop, out_free;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !skid_valid_q;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_pop       = out_valid_q && m_axis_tready;
  assign out_free      = out_pop || !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prg_bank_mask    <= 8'd63;
      cfg_q.chr_rom_present  <= 1'b1;
      cfg_q.four_screen      <= 1'b0;
      cfg_q.alt_irq_revision <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bsim_pkg::CFG_PRG_MASK: cfg_q.prg_bank_mask    <= cfg_data_i;
        bsim_pkg::CFG_CHR_ROM:  cfg_q.chr_rom_present  <= cfg_data_i[0];
        bsim_pkg::CFG_FOUR_SCR: cfg_q.four_screen      <= cfg_data_i[0];
        bsim_pkg::CFG_ALT_IRQ:  cfg_q.alt_irq_revision <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  bsim_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .item_en_i (in_accept),
    .mode_i    (bsim_pkg::mode_e'(s_axis_tuser)),
    .address_i (s_axis_tdata[15:0]),
    .data_i    (s_axis_tdata[23:16]),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || in_accept;
      skid_valid_q <= 1'b0;
    end else if (in_accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (in_accept) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_q.prg_ram_writable, out_q.prg_ram_enabled,
                          out_q.mirroring_horizontal, out_q.irq_line, out_q.bank};
  assign m_axis_tuser  = out_q.bank_is_rom;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without a result in the output register");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && out_valid_q && !m_axis_tready) |=> skid_valid_q)
    else $error("item accepted under stall was not kept in the skid entry");

  a_non_lookup_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !s_axis_tuser[1]) |-> (res.bank == 8'd0 && !res.bank_is_rom))
    else $error("write or A12 item produced a non-zero bank result");

endmodule
